// ===== design/raw10_row_stride_unpacker_assert.svh =====
// assertion macros for the packed raw10 unpacker
// used by the top level; clock clk and reset rst must be in scope
`ifndef RAW10_ROW_STRIDE_UNPACKER_ASSERT_SVH
`define RAW10_ROW_STRIDE_UNPACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RRSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrsu assertion failed");
// next-cycle implication
`define RRSU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrsu assertion failed");
`else
`define RRSU_ASSERT_IMP(lbl, ante, cons)
`define RRSU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/rrsu_pkg.sv =====
// shared types, constants and config helpers for the raw10 unpacker
// no dependencies
`timescale 1ns / 1ps
package rrsu_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int STRIDE_ALIGN = 32;

  localparam logic [12:0] ALIGN_MASK = 13'(STRIDE_ALIGN - 1);

  // register indexes on the config port
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_RIGHT_PADDING = 2'd2;

  // register defaults
  localparam logic [12:0] RST_FRAME_WIDTH   = 13'd2592;
  localparam logic [12:0] RST_FRAME_HEIGHT  = 13'd1944;
  localparam logic [7:0]  RST_RIGHT_PADDING = 8'd0;

  // derived row geometry
  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [12:0] stride;
    logic [12:0] group_bytes;
  } cfg_t;

  // one group of four pixels handed from front to back
  typedef struct packed {
    logic [3:0][7:0] held;
    logic [7:0]      tail;
    logic [11:0]     column;
    logic [11:0]     row;
    logic [1:0]      last_idx;
    logic            frame_end;
  } job_t;

  // queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // clamp raw registers and work out stride and group bytes
  function automatic cfg_t derive_cfg(logic [12:0] w_raw, logic [12:0] h_raw,
                                      logic [7:0] pad);
    cfg_t        c;
    logic [13:0] sum;
    logic [15:0] prod;
    logic [12:0] packed_bytes;
    logic [10:0] groups;
    c.width = w_raw;
    if (w_raw == 13'd0) c.width = 13'd1;
    else if (w_raw > 13'(MAX_WIDTH)) c.width = 13'(MAX_WIDTH);
    c.height = h_raw;
    if (h_raw == 13'd0) c.height = 13'd1;
    else if (h_raw > 13'(MAX_HEIGHT)) c.height = 13'(MAX_HEIGHT);
    sum          = 14'(c.width) + 14'(pad);
    prod         = {sum, 2'b00} + 16'(sum) + 16'd3;
    packed_bytes = prod[14:2];
    c.stride     = (packed_bytes + ALIGN_MASK) & ~ALIGN_MASK;
    groups       = 11'((14'(c.width) + 14'd3) >> 2);
    c.group_bytes = {groups, 2'b00} + 13'(groups);
    return c;
  endfunction

endpackage

// ===== design/rrsu_cfg.sv =====
// apb register file and derived row geometry
// depends on rrsu_pkg
`timescale 1ns / 1ps
module rrsu_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output rrsu_pkg::cfg_t    cfg
);

  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [7:0]  right_padding;
  logic [12:0] frame_width_next;
  logic [12:0] frame_height_next;
  logic [7:0]  right_padding_next;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register write decode
  always_comb begin
    frame_width_next   = frame_width;
    frame_height_next  = frame_height;
    right_padding_next = right_padding;
    if (wr_en) begin
      unique case (paddr[3:2])
        rrsu_pkg::REG_FRAME_WIDTH:   frame_width_next   = pwdata[12:0];
        rrsu_pkg::REG_FRAME_HEIGHT:  frame_height_next  = pwdata[12:0];
        rrsu_pkg::REG_RIGHT_PADDING: right_padding_next = pwdata[7:0];
        default: ;
      endcase
    end
  end

  // registers and geometry, geometry follows the write in the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= rrsu_pkg::RST_FRAME_WIDTH;
      frame_height  <= rrsu_pkg::RST_FRAME_HEIGHT;
      right_padding <= rrsu_pkg::RST_RIGHT_PADDING;
      cfg <= rrsu_pkg::derive_cfg(rrsu_pkg::RST_FRAME_WIDTH, rrsu_pkg::RST_FRAME_HEIGHT,
                                  rrsu_pkg::RST_RIGHT_PADDING);
    end else begin
      frame_width   <= frame_width_next;
      frame_height  <= frame_height_next;
      right_padding <= right_padding_next;
      cfg <= rrsu_pkg::derive_cfg(frame_width_next, frame_height_next, right_padding_next);
    end
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      rrsu_pkg::REG_FRAME_WIDTH:   prdata = {19'd0, frame_width};
      rrsu_pkg::REG_FRAME_HEIGHT:  prdata = {19'd0, frame_height};
      rrsu_pkg::REG_RIGHT_PADDING: prdata = {24'd0, right_padding};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/rrsu_front.sv =====
// front end: takes bytes, tracks row and group position, builds pixel groups
// depends on rrsu_pkg
`timescale 1ns / 1ps
module rrsu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // byte_value[7:0]
  input  rrsu_pkg::cfg_t       cfg,
  input  rrsu_pkg::fifo_stat_t fifo_stat,
  output logic                 push,
  output rrsu_pkg::job_t       job
);

  logic [12:0]     byte_in_row;
  logic [2:0]      byte_in_group;
  logic [3:0][7:0] held_bytes;
  logic [12:0]     group_column;
  logic [11:0]     row_count;

  logic [12:0]     byte_in_row_next;
  logic [2:0]      byte_in_group_next;
  logic [3:0][7:0] held_bytes_next;
  logic [12:0]     group_column_next;
  logic [11:0]     row_count_next;

  logic            accept;
  logic            group_done;
  logic            has_pixels;
  logic [12:0]     remain;
  logic [2:0]      pix_cnt;
  logic [12:0]     row_pos;
  logic [11:0]     grp_row;

  // next row index, wrapping at the frame height
  function automatic logic [11:0] wrap_row(logic [11:0] r, logic [12:0] h);
    logic [12:0] inc;
    inc = 13'(r) + 13'd1;
    return (inc >= h) ? 12'd0 : inc[11:0];
  endfunction

  assign s_axis_tready = ~fifo_stat.full;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // position update for one byte
  always_comb begin
    row_count_next     = row_count;
    byte_in_row_next   = byte_in_row;
    byte_in_group_next = byte_in_group;
    group_column_next  = group_column;
    held_bytes_next    = held_bytes;
    group_done         = 1'b0;
    // frame restart if height shrank under the current row
    if (13'(row_count) >= cfg.height) begin
      row_count_next     = 12'd0;
      byte_in_row_next   = 13'd0;
      byte_in_group_next = 3'd0;
      group_column_next  = 13'd0;
    end
    // row end if stride shrank under the current position
    if (byte_in_row_next >= cfg.stride) begin
      byte_in_row_next   = 13'd0;
      byte_in_group_next = 3'd0;
      group_column_next  = 13'd0;
      row_count_next     = wrap_row(row_count_next, cfg.height);
    end
    row_pos = group_column_next;
    if (byte_in_row_next < cfg.group_bytes) begin
      if (byte_in_group_next < 3'd4) begin
        held_bytes_next[byte_in_group_next[1:0]] = s_axis_tdata;
        byte_in_group_next = byte_in_group_next + 3'd1;
      end else begin
        group_done         = 1'b1;
        byte_in_group_next = 3'd0;
        group_column_next  = group_column_next + 13'd4;
      end
    end
    grp_row = row_count_next;
    byte_in_row_next = byte_in_row_next + 13'd1;
    if (byte_in_row_next >= cfg.stride) begin
      byte_in_row_next   = 13'd0;
      byte_in_group_next = 3'd0;
      group_column_next  = 13'd0;
      row_count_next     = wrap_row(row_count_next, cfg.height);
    end
  end

  // pixels of this group that fall inside the width
  always_comb begin
    has_pixels = row_pos < cfg.width;
    remain     = cfg.width - row_pos;
    pix_cnt    = (remain >= 13'd4) ? 3'd4 : remain[2:0];
    push       = accept & group_done & has_pixels;
    job.held      = held_bytes;
    job.tail      = s_axis_tdata;
    job.column    = row_pos[11:0];
    job.row       = grp_row;
    job.last_idx  = 2'(pix_cnt - 3'd1);
    job.frame_end = (13'(grp_row) == cfg.height - 13'd1) &&
                    (row_pos + 13'(pix_cnt) == cfg.width);
  end

  // position state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_row   <= 13'd0;
      byte_in_group <= 3'd0;
      held_bytes    <= '0;
      group_column  <= 13'd0;
      row_count     <= 12'd0;
    end else if (accept) begin
      byte_in_row   <= byte_in_row_next;
      byte_in_group <= byte_in_group_next;
      held_bytes    <= held_bytes_next;
      group_column  <= group_column_next;
      row_count     <= row_count_next;
    end
  end

endmodule

// ===== design/rrsu_fifo.sv =====
// four-entry queue of pixel groups between front and back
// depends on rrsu_pkg
`timescale 1ns / 1ps
module rrsu_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rrsu_pkg::job_t       push_job,
  input  logic                 pop,
  output rrsu_pkg::job_t       head,
  output rrsu_pkg::fifo_stat_t stat
);

  rrsu_pkg::job_t entries [4];
  logic [1:0]     wr_ptr;
  logic [1:0]     rd_ptr;
  logic [2:0]     count;

  assign head       = entries[rd_ptr];
  assign stat.full  = count == 3'd4;
  assign stat.empty = count == 3'd0;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

// ===== design/rrsu_back.sv =====
// back end: group to pixels, one per cycle unless stalled, into the output register
// depends on rrsu_pkg
`timescale 1ns / 1ps
module rrsu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rrsu_pkg::job_t       head,
  input  rrsu_pkg::fifo_stat_t fifo_stat,
  output logic                 pop,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // pixel_value[9:0], pixel_column[21:10],
                                              // pixel_row[33:22], zero fill
  output logic                 m_axis_tlast,  // last_of_group
  output logic                 m_axis_tuser   // frame_end
);

  logic [1:0] pix_idx;
  logic       load;
  logic       is_last;
  logic [9:0] pix_value;
  logic [7:0] tail_shift;

  assign load    = ~fifo_stat.empty & (~m_axis_tvalid | m_axis_tready);
  assign is_last = pix_idx == head.last_idx;
  assign pop     = load & is_last;

  // pixel assembly from its byte and two low bits from the tail byte
  always_comb begin
    tail_shift = head.tail >> {pix_idx, 1'b0};
    pix_value  = {head.held[pix_idx], tail_shift[1:0]};
  end

  // pixel index within the group
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_idx <= 2'd0;
    end else if (load) begin
      pix_idx <= is_last ? 2'd0 : pix_idx + 2'd1;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {6'd0, head.row, head.column + 12'(pix_idx), pix_value};
      m_axis_tlast <= is_last;
      m_axis_tuser <= is_last & head.frame_end;
    end
  end

endmodule

// ===== design/raw10_row_stride_unpacker.sv =====
// packed raw10 unpacker with row stride: five bytes in, four 10-bit pixels out.
// takes one byte per cycle and emits one pixel per cycle, when not stalled, from a
// single output register; a group's fifth byte writes it into the queue, from which
// its first pixel loads. bytes stall only when the four-entry group queue is full.
// synchronous reset clears position, queue and output valid; registers return to
// width 2592, height 1944, padding 0.
`timescale 1ns / 1ps
`include "raw10_row_stride_unpacker_assert.svh"
module raw10_row_stride_unpacker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // pixel_value[9:0], pixel_column[21:10],
                                      // pixel_row[33:22], zero fill
  output logic        m_axis_tlast,   // last_of_group
  output logic        m_axis_tuser,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rrsu_pkg::cfg_t       cfg;
  rrsu_pkg::fifo_stat_t fifo_stat;
  rrsu_pkg::job_t       push_job;
  rrsu_pkg::job_t       head;
  logic                 push;
  logic                 pop;

  // config registers
  rrsu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // byte intake and group building
  rrsu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg           (cfg),
    .fifo_stat     (fifo_stat),
    .push          (push),
    .job           (push_job)
  );

  // group queue
  rrsu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  // pixel output
  rrsu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .fifo_stat     (fifo_stat),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // checks
  `RRSU_ASSERT_IMP(a_no_push_full, push, !fifo_stat.full)
  `RRSU_ASSERT_IMP(a_no_pop_empty, pop, !fifo_stat.empty)
  `RRSU_ASSERT_IMP(a_frame_end_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `RRSU_ASSERT_NXT(a_pop_shows_last, pop, m_axis_tvalid && m_axis_tlast)

endmodule
